@@ design/pvm_pkg.sv @@
// Shared types and constants for the PCM voice mixer.
// Holds the request and result structs, command codes and fixed field widths.
// No dependencies.
package pvm_pkg;

  localparam int ID_W       = 4;
  localparam int LEN_W      = 17;
  localparam int DESC_DEPTH = 16;
  // start (16 bits) + position (17 bits) needs 18 bits
  localparam int SUM_W      = 18;

  typedef enum logic [2:0] {
    CMD_WRITE_SAMPLE = 3'd0,
    CMD_WRITE_DESC   = 3'd1,
    CMD_START_EFFECT = 3'd2,
    CMD_SELECT_TRACK = 3'd3,
    CMD_PRODUCE      = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0]        command;
    logic [15:0]       address;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
    logic [ID_W-1:0]   sound_id;
    logic [15:0]       sound_start;
    logic [LEN_W-1:0]  sound_length;
  } req_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
  } res_t;

endpackage

@@ design/pvm_mod_unit.sv @@
// Reduction of a frame address modulo the sample store size.
// Reciprocal multiply for the quotient estimate, then one compare and subtract.
// Depends on pvm_pkg for the address sum width.
module pvm_mod_unit #(
  parameter int SAMPLE_FRAMES = 65536
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [pvm_pkg::SUM_W-1:0]        value_i,
  output logic                             done_o,
  output logic [$clog2(SAMPLE_FRAMES)-1:0] addr_o
);

  localparam int AW = $clog2(SAMPLE_FRAMES);
  localparam int SW = pvm_pkg::SUM_W;
  localparam int RW = SW + 1;
  localparam int CW = ((AW > SW) ? AW : SW) + 1;
  localparam logic [CW-1:0] MODV  = CW'(SAMPLE_FRAMES);
  // floor(2^SW / SAMPLE_FRAMES): the quotient estimate is low by at most one
  localparam logic [RW-1:0] RECIP = RW'((64'd1 << SW) / 64'(SAMPLE_FRAMES));

  typedef enum logic [1:0] {
    M_IDLE,
    M_QUOT,
    M_REM,
    M_FIX
  } state_e;

  state_e           state_q;
  logic [SW-1:0]    val_q;
  logic [RW-1:0]    quot_q;
  logic [CW-1:0]    rem_q;
  logic             done_q;
  logic [SW+RW-1:0] prod;
  logic [CW-1:0]    qm;

  assign prod = val_q * RECIP;
  assign qm   = CW'(quot_q) * MODV;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      val_q   <= '0;
      quot_q  <= '0;
      rem_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      unique case (state_q)
        M_IDLE: begin
          done_q <= 1'b0;
          if (start_i) begin
            val_q   <= value_i;
            state_q <= M_QUOT;
          end
        end
        M_QUOT: begin
          quot_q  <= prod[SW+RW-1:SW];
          state_q <= M_REM;
        end
        M_REM: begin
          rem_q   <= {{(CW-SW){1'b0}}, val_q} - qm;
          state_q <= M_FIX;
        end
        M_FIX: begin
          // remainder estimate is below twice the store size
          if (rem_q >= MODV) begin
            rem_q <= rem_q - MODV;
          end
          done_q  <= 1'b1;
          state_q <= M_IDLE;
        end
        default: begin
          state_q <= M_IDLE;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign addr_o = rem_q[AW-1:0];

endmodule

@@ design/pcm_voice_mixer_with_allocation_top.sv @@
// PCM voice mixer top level: sequencer, descriptors, voices and sample store.
// Depends on pvm_pkg and pvm_mod_unit.
//
// Usage: a request (req_i) is taken at a rising edge where start is high and
// busy is low. Write descriptor, start effect, select track and unknown
// commands complete in the accept cycle and leave busy low. Write sample
// frame holds busy while the address is reduced modulo
// SAMPLE_FRAMES by a three-step reciprocal unit.
// Produce frame walks the track and then each voice in order through one
// shared address reduction unit and one store read port; only a source that
// plays makes a store read; an idle track or an idle or finished voice is
// passed over without one. The mixed frame appears on res_o for exactly one
// cycle with res_valid_o high; the receiver cannot hold it, and busy is
// already low in that cycle. The enable register (cfg_*) is written whenever
// cfg_valid_i is high; it is always ready. Reset clears descriptors, voices,
// the track and sets enable; the sample store is not cleared and must be
// written first.
module pcm_voice_mixer_with_allocation_top #(
  parameter int VOICE_COUNT   = 4,
  parameter int SOUND_COUNT   = 16,
  parameter int SAMPLE_FRAMES = 65536
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  pvm_pkg::req_t req_i,
  output logic          res_valid_o,
  output pvm_pkg::res_t res_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_data_i
);

  localparam int AW  = $clog2(SAMPLE_FRAMES);
  localparam int SW  = pvm_pkg::SUM_W;
  localparam int LW  = pvm_pkg::LEN_W;
  localparam int IW  = pvm_pkg::ID_W;
  localparam int DD  = pvm_pkg::DESC_DEPTH;
  localparam int VW  = $clog2(VOICE_COUNT + 1);
  localparam int VIW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam logic [8:0] SOUND_LIMIT = 9'(SOUND_COUNT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_TRACK,
    S_VOICE,
    S_FETCH,
    S_ADD
  } state_e;

  state_e state_q;

  logic              enable_q;
  logic [15:0]       desc_start_q [DD];
  logic [LW-1:0]     desc_len_q   [DD];
  logic [IW-1:0]     voice_sound_q [VOICE_COUNT];
  logic [LW-1:0]     voice_pos_q   [VOICE_COUNT];
  logic              voice_busy_q  [VOICE_COUNT];
  logic [IW-1:0]     track_sound_q;
  logic [LW-1:0]     track_pos_q;
  logic [VW-1:0]     vidx_q;
  logic signed [15:0] acc_l_q;
  logic signed [15:0] acc_r_q;
  logic              mod_start_q;
  logic [SW-1:0]     mod_value_q;
  logic [31:0]       wdata_q;
  logic              res_valid_q;
  pvm_pkg::res_t     res_q;

  logic [31:0]       store_q [SAMPLE_FRAMES];
  logic [31:0]       rd_q;

  logic              accept;
  logic              mod_done;
  logic [AW-1:0]     mod_addr;
  logic [VIW-1:0]    vi;
  logic [IW-1:0]     sel_id;
  logic [15:0]       sel_start;
  logic [LW-1:0]     sel_len;
  logic [LW-1:0]     track_pos_eff;
  logic [LW-1:0]     src_pos;
  logic [SW-1:0]     frame_sum;
  logic              id_ok;
  logic [VIW-1:0]    pick;
  logic              found;
  logic signed [16:0] sum_l;
  logic signed [16:0] sum_r;
  logic signed [15:0] sat_l;
  logic signed [15:0] sat_r;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    if (v > 17'sd32767) begin
      return 16'sh7fff;
    end else if (v < -17'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  pvm_mod_unit #(
    .SAMPLE_FRAMES(SAMPLE_FRAMES)
  ) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mod_start_q),
    .value_i(mod_value_q),
    .done_o (mod_done),
    .addr_o (mod_addr)
  );

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign vi            = vidx_q[VIW-1:0];
  assign sel_id        = (state_q == S_TRACK) ? track_sound_q : voice_sound_q[vi];
  assign sel_start     = desc_start_q[sel_id];
  assign sel_len       = desc_len_q[sel_id];
  // loop the track back to its first frame once it has run past its end
  assign track_pos_eff = (track_pos_q >= sel_len) ? '0 : track_pos_q;
  assign src_pos       = (state_q == S_TRACK) ? track_pos_eff : voice_pos_q[vi];
  assign frame_sum     = {2'b00, sel_start} + {1'b0, src_pos};
  assign id_ok         = {5'b00000, req_i.sound_id} < SOUND_LIMIT;

  assign sum_l = {acc_l_q[15], acc_l_q} + {rd_q[15], rd_q[15:0]};
  assign sum_r = {acc_r_q[15], acc_r_q} + {rd_q[31], rd_q[31:16]};
  assign sat_l = sat16(sum_l);
  assign sat_r = sat16(sum_r);

  // voice for a new effect: same sound playing, else first free, else voice 0
  always_comb begin
    pick  = '0;
    found = 1'b0;
    for (int i = 0; i < VOICE_COUNT; i++) begin
      if (!found && voice_busy_q[i] && voice_sound_q[i] == req_i.sound_id) begin
        pick  = VIW'(i);
        found = 1'b1;
      end
    end
    for (int i = 0; i < VOICE_COUNT; i++) begin
      if (!found && !voice_busy_q[i]) begin
        pick  = VIW'(i);
        found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_WRITE && mod_done) begin
      store_q[mod_addr] <= wdata_q;
    end
    if (state_q == S_FETCH && mod_done) begin
      rd_q <= store_q[mod_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      enable_q      <= 1'b1;
      track_sound_q <= '0;
      track_pos_q   <= '0;
      vidx_q        <= '0;
      acc_l_q       <= '0;
      acc_r_q       <= '0;
      mod_start_q   <= 1'b0;
      mod_value_q   <= '0;
      wdata_q       <= '0;
      res_valid_q   <= 1'b0;
      res_q         <= '0;
      for (int i = 0; i < DD; i++) begin
        desc_start_q[i] <= '0;
        desc_len_q[i]   <= '0;
      end
      for (int i = 0; i < VOICE_COUNT; i++) begin
        voice_sound_q[i] <= '0;
        voice_pos_q[i]   <= '0;
        voice_busy_q[i]  <= 1'b0;
      end
    end else begin
      mod_start_q <= 1'b0;
      res_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        enable_q <= cfg_data_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (pvm_pkg::cmd_e'(req_i.command))
              pvm_pkg::CMD_WRITE_SAMPLE: begin
                mod_value_q <= {2'b00, req_i.address};
                mod_start_q <= 1'b1;
                wdata_q     <= {req_i.right_in, req_i.left_in};
                state_q     <= S_WRITE;
              end
              pvm_pkg::CMD_WRITE_DESC: begin
                if (id_ok) begin
                  desc_start_q[req_i.sound_id] <= req_i.sound_start;
                  desc_len_q[req_i.sound_id]   <= req_i.sound_length;
                end
              end
              pvm_pkg::CMD_START_EFFECT: begin
                if (enable_q && req_i.sound_id != '0 && id_ok) begin
                  voice_sound_q[pick] <= req_i.sound_id;
                  voice_pos_q[pick]   <= '0;
                  voice_busy_q[pick]  <= 1'b1;
                end
              end
              pvm_pkg::CMD_SELECT_TRACK: begin
                if (enable_q && id_ok && req_i.sound_id != track_sound_q) begin
                  track_sound_q <= req_i.sound_id;
                  track_pos_q   <= '0;
                end
              end
              pvm_pkg::CMD_PRODUCE: begin
                acc_l_q <= '0;
                acc_r_q <= '0;
                state_q <= S_TRACK;
              end
              default: begin
              end
            endcase
          end
        end
        S_WRITE: begin
          if (mod_done) begin
            state_q <= S_IDLE;
          end
        end
        S_TRACK: begin
          vidx_q <= '0;
          if (track_sound_q != '0 && sel_len != '0) begin
            mod_value_q <= frame_sum;
            mod_start_q <= 1'b1;
            track_pos_q <= track_pos_eff + LW'(1);
            state_q     <= S_FETCH;
          end else begin
            state_q <= S_VOICE;
          end
        end
        S_VOICE: begin
          if (vidx_q == VW'(VOICE_COUNT)) begin
            res_q.left_out  <= acc_l_q;
            res_q.right_out <= acc_r_q;
            res_valid_q     <= 1'b1;
            state_q         <= S_IDLE;
          end else begin
            vidx_q <= vidx_q + VW'(1);
            if (voice_busy_q[vi]) begin
              // free a voice that has played out or lost its sound
              if (voice_pos_q[vi] >= sel_len) begin
                voice_busy_q[vi] <= 1'b0;
              end else begin
                mod_value_q     <= frame_sum;
                mod_start_q     <= 1'b1;
                voice_pos_q[vi] <= voice_pos_q[vi] + LW'(1);
                state_q         <= S_FETCH;
              end
            end
          end
        end
        S_FETCH: begin
          if (mod_done) begin
            state_q <= S_ADD;
          end
        end
        S_ADD: begin
          acc_l_q <= sat_l;
          acc_r_q <= sat_r;
          state_q <= S_VOICE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the PCM voice mixer top level.
// Depends on pvm_pkg and pcm_voice_mixer_with_allocation_top; predicts each mixed frame
// from a local model of descriptors, voices and track, and checks every strobed result.
`timescale 1ns / 1ps

module testbench;

  localparam int NVOICE       = 4;
  localparam int NSOUND       = 16;
  localparam int NFRAME       = 65536;
  localparam int DRAIN_CYCLES = 60;
  localparam int PLAN         = 0;
  localparam int LIVE         = 1;
  localparam logic [15:0] SAMPLE_MAX = 16'h7FFF;
  localparam logic [15:0] SAMPLE_MIN = 16'h8000;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          start       = 1'b0;
  logic          busy;
  pvm_pkg::req_t req_i       = '0;
  logic          res_valid_o;
  pvm_pkg::res_t res_o;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic          cfg_data_i  = 1'b0;

  // Mixer state, kept twice: PLAN runs ahead at generation time, LIVE follows accepted requests.
  bit [15:0] snd_start [2][NSOUND];
  bit [16:0] snd_len   [2][NSOUND];
  bit [3:0]  vc_sound  [2][NVOICE];
  bit [16:0] vc_pos    [2][NVOICE];
  bit        vc_on     [2][NVOICE];
  bit [3:0]  trk_sound [2];
  bit [16:0] trk_pos   [2];
  bit        mix_en    [2] = '{1'b1, 1'b1};
  bit [15:0] read_addr [2][NVOICE+1];

  logic [31:0] frame_mem    [NFRAME];
  bit          frame_loaded [NFRAME];

  pvm_pkg::req_t cmd_queue[$];
  pvm_pkg::res_t expected_frames[$];
  int   n_sent   = 0;
  int   n_taken  = 0;
  int   n_bad    = 0;
  int   n_queued = 0;
  int   idle_pct = 0;

  int phase_items [4] = '{500, 250, 400, 400};
  int phase_idle  [4] = '{0, 62, 0, 34};
  bit phase_en    [4] = '{1'b1, 1'b0, 1'b1, 1'b1};

  pcm_voice_mixer_with_allocation_top #(
    .VOICE_COUNT  (NVOICE),
    .SOUND_COUNT  (NSOUND),
    .SAMPLE_FRAMES(NFRAME)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic int clip16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Update one side's mixer state for a request; for a frame, return how many store
  // reads it makes (addresses left in read_addr), otherwise -1. Store writes are not handled.
  function automatic int advance_mixer(int side, pvm_pkg::req_t rq);
    int         slot;
    int         n;
    logic [3:0] id;
    bit [3:0]   ts;
    id   = rq.sound_id;
    slot = -1;
    n    = 0;
    case (rq.command)
      pvm_pkg::CMD_WRITE_DESC: begin
        snd_start[side][id] = rq.sound_start;
        snd_len[side][id]   = rq.sound_length;
      end
      pvm_pkg::CMD_START_EFFECT: begin
        if (mix_en[side] && id != 0) begin
          for (int v = 0; v < NVOICE; v++)
            if (slot < 0 && vc_on[side][v] && vc_sound[side][v] == id) slot = v;
          for (int v = 0; v < NVOICE; v++)
            if (slot < 0 && !vc_on[side][v]) slot = v;
          if (slot < 0) slot = 0;
          vc_sound[side][slot] = id;
          vc_pos[side][slot]   = '0;
          vc_on[side][slot]    = 1'b1;
        end
      end
      pvm_pkg::CMD_SELECT_TRACK: begin
        if (mix_en[side] && id != trk_sound[side]) begin
          trk_sound[side] = id;
          trk_pos[side]   = '0;
        end
      end
      pvm_pkg::CMD_PRODUCE: begin
        ts = trk_sound[side];
        if (ts != 0 && snd_len[side][ts] != 0) begin
          // loop the track back to its first frame
          if (trk_pos[side] >= snd_len[side][ts]) trk_pos[side] = '0;
          read_addr[side][n] = snd_start[side][ts] + trk_pos[side][15:0];
          n++;
          trk_pos[side] = trk_pos[side] + 1'b1;
        end
        for (int v = 0; v < NVOICE; v++) begin
          if (vc_on[side][v]) begin
            if (snd_len[side][vc_sound[side][v]] == 0 ||
                vc_pos[side][v] >= snd_len[side][vc_sound[side][v]]) begin
              vc_on[side][v] = 1'b0;
            end else begin
              read_addr[side][n] = snd_start[side][vc_sound[side][v]] + vc_pos[side][v][15:0];
              n++;
              vc_pos[side][v] = vc_pos[side][v] + 1'b1;
            end
          end
        end
        return n;
      end
      default: ;
    endcase
    return -1;
  endfunction

  function automatic logic [15:0] pick_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) return SAMPLE_MAX;
    if (pick < 30) return SAMPLE_MIN;
    return 16'($urandom);
  endfunction

  function automatic pvm_pkg::req_t cmd_of(logic [2:0] cmd, logic [3:0] id, logic [15:0] addr,
                                           logic [15:0] lft, logic [15:0] rgt,
                                           logic [15:0] first, logic [16:0] len);
    pvm_pkg::req_t rq;
    rq.command      = cmd;
    rq.sound_id     = id;
    rq.address      = addr;
    rq.left_in      = lft;
    rq.right_in     = rgt;
    rq.sound_start  = first;
    rq.sound_length = len;
    return rq;
  endfunction

  function automatic pvm_pkg::req_t random_cmd();
    pvm_pkg::req_t rq;
    int            pick;
    bit [16:0]     span;
    pick = $urandom_range(99);
    if (pick < 40)      rq.command = pvm_pkg::CMD_PRODUCE;
    else if (pick < 58) rq.command = pvm_pkg::CMD_WRITE_SAMPLE;
    else if (pick < 72) rq.command = pvm_pkg::CMD_START_EFFECT;
    else if (pick < 80) rq.command = pvm_pkg::CMD_SELECT_TRACK;
    else if (pick < 96) rq.command = pvm_pkg::CMD_WRITE_DESC;
    else                rq.command = 3'(pvm_pkg::CMD_PRODUCE + 1 + $urandom_range(2));
    pick = $urandom_range(99);
    if (pick < 8)       rq.sound_id = '0;
    else if (pick < 80) rq.sound_id = 4'($urandom_range(6, 1));
    else                rq.sound_id = 4'($urandom_range(15, 7));
    rq.address  = 16'($urandom);
    rq.left_in  = pick_sample();
    rq.right_in = pick_sample();
    pick = $urandom_range(99);
    // starts near the top of the store make reads wrap to address zero
    if (pick < 25) rq.sound_start = 16'hFFFF - 16'($urandom_range(47));
    else           rq.sound_start = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 5)       rq.sound_length = '0;
    else if (pick < 8)  rq.sound_length = 17'(NFRAME);
    else if (pick < 12) rq.sound_length = 17'($urandom_range(NFRAME));
    else                rq.sound_length = 17'($urandom_range(48, 1));
    span = snd_len[PLAN][rq.sound_id];
    // overwrite frames of a loaded sound half the time
    if (rq.command == pvm_pkg::CMD_WRITE_SAMPLE && span != 0 && $urandom_range(1))
      rq.address = snd_start[PLAN][rq.sound_id] + 16'($urandom_range(span > 64 ? 63 : span - 1));
    return rq;
  endfunction

  // Queue a request; before a frame, write any store entry it reads that was never written.
  function automatic void enqueue_cmd(pvm_pkg::req_t rq);
    int            n;
    pvm_pkg::req_t fill;
    if (rq.command == pvm_pkg::CMD_WRITE_SAMPLE) frame_loaded[rq.address] = 1'b1;
    n = advance_mixer(PLAN, rq);
    for (int k = 0; k < n; k++) begin
      if (!frame_loaded[read_addr[PLAN][k]]) begin
        fill         = random_cmd();
        fill.command = pvm_pkg::CMD_WRITE_SAMPLE;
        fill.address = read_addr[PLAN][k];
        cmd_queue.push_back(fill);
        n_queued++;
        frame_loaded[read_addr[PLAN][k]] = 1'b1;
      end
    end
    cmd_queue.push_back(rq);
    n_queued++;
  endfunction

  task automatic drain_all();
    while (cmd_queue.size() != 0 || n_taken != n_sent || expected_frames.size() != 0 || busy)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    // hold the request until it is taken
    if (!start || n_taken == n_sent) begin
      if (cmd_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        req_i <= cmd_queue.pop_front();
        start <= 1'b1;
        n_sent++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    pvm_pkg::res_t want;
    int            n;
    int            lsum;
    int            rsum;
    if (rst_ni && res_valid_o) begin
      if (expected_frames.size() == 0) begin
        $display("%0t: frame with none expected, got left %0d right %0d",
                 $time, res_o.left_out, res_o.right_out);
        n_bad++;
      end else begin
        want = expected_frames.pop_front();
        if (res_o.left_out !== want.left_out) begin
          $display("%0t: left_out expected %0d got %0d", $time, want.left_out, res_o.left_out);
          n_bad++;
        end
        if (res_o.right_out !== want.right_out) begin
          $display("%0t: right_out expected %0d got %0d", $time, want.right_out, res_o.right_out);
          n_bad++;
        end
      end
    end
    if (rst_ni && start && !busy) begin
      n_taken++;
      if (req_i.command == pvm_pkg::CMD_WRITE_SAMPLE) begin
        frame_mem[req_i.address] = {req_i.right_in, req_i.left_in};
      end else begin
        n = advance_mixer(LIVE, req_i);
        if (n >= 0) begin
          lsum = 0;
          rsum = 0;
          // saturate after every source, track first, then voices in order
          for (int k = 0; k < n; k++) begin
            lsum = clip16(lsum + $signed(frame_mem[read_addr[LIVE][k]][15:0]));
            rsum = clip16(rsum + $signed(frame_mem[read_addr[LIVE][k]][31:16]));
          end
          want.left_out  = lsum[15:0];
          want.right_out = rsum[15:0];
          expected_frames.push_back(want);
        end
      end
    end
  end

  initial begin
    int phase_end;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      drain_all();
      cfg_valid_i <= 1'b1;
      cfg_data_i  <= phase_en[ph];
      do @(posedge clk_i); while (!cfg_ready_o);
      mix_en[PLAN] = phase_en[ph];
      mix_en[LIVE] = phase_en[ph];
      idle_pct     = phase_idle[ph];
      if (ph == 0) begin
        enqueue_cmd(cmd_of(pvm_pkg::CMD_PRODUCE, '0, '0, '0, '0, '0, '0));
        enqueue_cmd(cmd_of(pvm_pkg::CMD_WRITE_SAMPLE, '0, 16'hFFFF,
                           SAMPLE_MAX, SAMPLE_MIN, '0, '0));
        enqueue_cmd(cmd_of(pvm_pkg::CMD_WRITE_SAMPLE, '0, 16'h0000,
                           SAMPLE_MAX, SAMPLE_MIN, '0, '0));
        enqueue_cmd(cmd_of(pvm_pkg::CMD_WRITE_SAMPLE, '0, 16'h0001,
                           SAMPLE_MIN, SAMPLE_MAX, '0, '0));
        enqueue_cmd(cmd_of(pvm_pkg::CMD_WRITE_DESC, 4'd1, '0, '0, '0, 16'hFFFF, 17'd3));
        enqueue_cmd(cmd_of(pvm_pkg::CMD_WRITE_DESC, 4'd2, '0, '0, '0, 16'hFFFF, 17'd1));
        enqueue_cmd(cmd_of(pvm_pkg::CMD_WRITE_DESC, 4'd15, '0, '0, '0, 16'h0000,
                           17'(NFRAME)));
        enqueue_cmd(cmd_of(pvm_pkg::CMD_WRITE_DESC, 4'd0, '0, '0, '0, 16'h1234, 17'd5));
        enqueue_cmd(cmd_of(pvm_pkg::CMD_SELECT_TRACK, 4'd1, '0, '0, '0, '0, '0));
        enqueue_cmd(cmd_of(pvm_pkg::CMD_START_EFFECT, 4'd1, '0, '0, '0, '0, '0));
        enqueue_cmd(cmd_of(pvm_pkg::CMD_START_EFFECT, 4'd0, '0, '0, '0, '0, '0));
        enqueue_cmd(cmd_of(pvm_pkg::CMD_START_EFFECT, 4'd9, '0, '0, '0, '0, '0));
        enqueue_cmd(cmd_of(pvm_pkg::CMD_PRODUCE, '0, '0, '0, '0, '0, '0));
        enqueue_cmd(cmd_of(pvm_pkg::CMD_START_EFFECT, 4'd1, '0, '0, '0, '0, '0));
        enqueue_cmd(cmd_of(pvm_pkg::CMD_START_EFFECT, 4'd2, '0, '0, '0, '0, '0));
        enqueue_cmd(cmd_of(pvm_pkg::CMD_START_EFFECT, 4'd15, '0, '0, '0, '0, '0));
        enqueue_cmd(cmd_of(pvm_pkg::CMD_START_EFFECT, 4'd3, '0, '0, '0, '0, '0));
        // all voices busy: steal voice 0
        enqueue_cmd(cmd_of(pvm_pkg::CMD_START_EFFECT, 4'd4, '0, '0, '0, '0, '0));
        enqueue_cmd(cmd_of(pvm_pkg::CMD_PRODUCE, '0, '0, '0, '0, '0, '0));
        enqueue_cmd(cmd_of(pvm_pkg::CMD_SELECT_TRACK, 4'd1, '0, '0, '0, '0, '0));
        enqueue_cmd(cmd_of(pvm_pkg::CMD_PRODUCE, '0, '0, '0, '0, '0, '0));
        enqueue_cmd(cmd_of(pvm_pkg::CMD_PRODUCE, '0, '0, '0, '0, '0, '0));
        enqueue_cmd(cmd_of(pvm_pkg::CMD_SELECT_TRACK, 4'd3, '0, '0, '0, '0, '0));
        enqueue_cmd(cmd_of(pvm_pkg::CMD_PRODUCE, '0, '0, '0, '0, '0, '0));
        for (int c = pvm_pkg::CMD_PRODUCE + 1; c < 8; c++)
          enqueue_cmd(cmd_of(3'(c), 4'd1, 16'hFFFF, SAMPLE_MAX, SAMPLE_MAX, 16'hFFFF, 17'd1));
        enqueue_cmd(cmd_of(pvm_pkg::CMD_SELECT_TRACK, 4'd0, '0, '0, '0, '0, '0));
        enqueue_cmd(cmd_of(pvm_pkg::CMD_PRODUCE, '0, '0, '0, '0, '0, '0));
      end
      // store fills count toward the phase's share of requests
      phase_end = n_queued + phase_items[ph];
      while (n_queued < phase_end) enqueue_cmd(random_cmd());
      @(negedge clk_i);
      cfg_valid_i <= 1'b0;
    end
    drain_all();
    if (n_bad == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
